@@ rtl/core/mcc_pkg.sv @@
package mcc_pkg;

  // Grid extent along each axis; a cube's base index may be at most GridSize - 2.
  localparam int unsigned GridSize = 256;
  // Quotient bits produced by the serial divider (Q0.16 plus one rounding bit).
  localparam int unsigned DivSteps = 17;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EDGE,
    S_DIV,
    S_ROUND,
    S_MUL,
    S_ACC,
    S_OUT
  } state_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ISO   = 3'd0,
    REG_VOXEL = 3'd1,
    REG_ORG_X = 3'd2,
    REG_ORG_Y = 3'd3,
    REG_ORG_Z = 3'd4
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       edge_setup;
    logic       div_step;
    logic       div_round;
    logic       mul;
    logic       acc;
    logic [3:0] slot;
    logic [1:0] vert;
    logic [1:0] axis;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       grid_ok;
    logic [2:0] ntri;
    logic       need_div;
  } dp_stat_t;

  // Triangle table: one cut edge per nibble, first edge in the top nibble, padded with f.
  localparam logic [63:0] TriTable [256] = '{
    64'hffffffffffffffff, 64'h083fffffffffffff, 64'h019fffffffffffff, 64'h183981ffffffffff,
    64'h12afffffffffffff, 64'h08312affffffffff, 64'h92a029ffffffffff, 64'h2832a8a98fffffff,
    64'h3b2fffffffffffff, 64'h0b28b0ffffffffff, 64'h19023bffffffffff, 64'h1b219b98bfffffff,
    64'h3a1ba3ffffffffff, 64'h0a108a8bafffffff, 64'h3903b9ba9fffffff, 64'h98aa8bffffffffff,
    64'h478fffffffffffff, 64'h430734ffffffffff, 64'h019847ffffffffff, 64'h419471731fffffff,
    64'h12a847ffffffffff, 64'h34730412afffffff, 64'h92a902847fffffff, 64'h2a9297273794ffff,
    64'h8473b2ffffffffff, 64'hb47b24204fffffff, 64'h90184723bfffffff, 64'h47b94b9b2921ffff,
    64'h3a13ba784fffffff, 64'h1ba14b1047b4ffff, 64'h47890b9bab03ffff, 64'h47b4b99bafffffff,
    64'h954fffffffffffff, 64'h954083ffffffffff, 64'h054150ffffffffff, 64'h854835315fffffff,
    64'h12a954ffffffffff, 64'h30812a495fffffff, 64'h52a542402fffffff, 64'h2a5325354348ffff,
    64'h95423bffffffffff, 64'h0b208b495fffffff, 64'h05401523bfffffff, 64'h21525828b485ffff,
    64'ha3ba13954fffffff, 64'h4950818a18baffff, 64'h54050b5bab03ffff, 64'h54858aa8bfffffff,
    64'h978579ffffffffff, 64'h930953573fffffff, 64'h078017157fffffff, 64'h153357ffffffffff,
    64'h978957a12fffffff, 64'ha12950530573ffff, 64'h802825857a52ffff, 64'h2a5253357fffffff,
    64'h7957893b2fffffff, 64'h95797292027bffff, 64'h23b018178157ffff, 64'hb21b17715fffffff,
    64'h958857a13a3bffff, 64'h5705097b010aba0f, 64'hba0b03a50807570f, 64'hba57b5ffffffffff,
    64'ha65fffffffffffff, 64'h0835a6ffffffffff, 64'h9015a6ffffffffff, 64'h1831985a6fffffff,
    64'h165261ffffffffff, 64'h165126308fffffff, 64'h965906026fffffff, 64'h598582526328ffff,
    64'h23ba65ffffffffff, 64'hb08b20a65fffffff, 64'h01923b5a6fffffff, 64'h5a61929b298bffff,
    64'h63b653513fffffff, 64'h08b0b50515b6ffff, 64'h3b6036065059ffff, 64'h65969bb98fffffff,
    64'h5a6478ffffffffff, 64'h43047365afffffff, 64'h1905a6847fffffff, 64'ha65197173794ffff,
    64'h612651478fffffff, 64'h125526304347ffff, 64'h847905065026ffff, 64'h739794329596269f,
    64'h3b2784a65fffffff, 64'h5a647242027bffff, 64'h01947823b5a6ffff, 64'h9219b294b7b45a6f,
    64'h8473b53515b6ffff, 64'h51b5b610b7b404bf, 64'h059065036b63847f, 64'h65969b4797b9ffff,
    64'ha4964affffffffff, 64'h4a649a083fffffff, 64'ha01a60640fffffff, 64'h83181686461affff,
    64'h149124264fffffff, 64'h308129249264ffff, 64'h024426ffffffffff, 64'h832824426fffffff,
    64'ha49a64b23fffffff, 64'h08228b49a4a6ffff, 64'h3b201606461affff, 64'h64161a48121b8b1f,
    64'h964936913b63ffff, 64'h8b1810b61914641f, 64'h3b6360064fffffff, 64'h648b68ffffffffff,
    64'h7a678a89afffffff, 64'h0730a709a67affff, 64'ha671a7178180ffff, 64'ha67a71173fffffff,
    64'h126168189867ffff, 64'h269291679093739f, 64'h780706602fffffff, 64'h732672ffffffffff,
    64'h23ba68a89867ffff, 64'h20727b09767a9a7f, 64'h1801781a767a23bf, 64'hb21b17a61671ffff,
    64'h896867916b63136f, 64'h091b67ffffffffff, 64'h7807063b0b60ffff, 64'h7b6fffffffffffff,
    64'h76bfffffffffffff, 64'h308b76ffffffffff, 64'h019b76ffffffffff, 64'h819831b76fffffff,
    64'ha126b7ffffffffff, 64'h12a3086b7fffffff, 64'h2902a96b7fffffff, 64'h6b72a3a83a98ffff,
    64'h723627ffffffffff, 64'h708760620fffffff, 64'h276237019fffffff, 64'h162181198876ffff,
    64'ha76a17137fffffff, 64'ha7617a187108ffff, 64'h03707a0a96a7ffff, 64'h76a7a88a9fffffff,
    64'h684b86ffffffffff, 64'h36b306046fffffff, 64'h86b846901fffffff, 64'h946963931b36ffff,
    64'h6846b82a1fffffff, 64'h12a30b06b046ffff, 64'h4b846b0292a9ffff, 64'ha93a32943b36463f,
    64'h823842462fffffff, 64'h042462ffffffffff, 64'h190234246438ffff, 64'h194142246fffffff,
    64'h8138618466a1ffff, 64'ha10a06604fffffff, 64'h4634386a3039a93f, 64'ha946a4ffffffffff,
    64'h49576bffffffffff, 64'h083495b76fffffff, 64'h50154076bfffffff, 64'hb76834354315ffff,
    64'h954a1276bfffffff, 64'h6b712a083495ffff, 64'h76b54a42a402ffff, 64'h348354325a52b76f,
    64'h723762549fffffff, 64'h954086062687ffff, 64'h362376150540ffff, 64'h628687218485158f,
    64'h954a16176137ffff, 64'h16a176107870954f, 64'h40a4a503a6a737af, 64'h76a7a854a48affff,
    64'h6956b9b89fffffff, 64'h36b036056095ffff, 64'h0b805b01556bffff, 64'h6b3635531fffffff,
    64'h12a95b9b8b56ffff, 64'h0b306b09656912af, 64'hb85b56805a52025f, 64'h6b36352a3a53ffff,
    64'h589528562382ffff, 64'h956960062fffffff, 64'h158180568382628f, 64'h156216ffffffffff,
    64'h13616a386569896f, 64'ha10a06950560ffff, 64'h03856affffffffff, 64'ha56fffffffffffff,
    64'hb5a75bffffffffff, 64'hb5ab75830fffffff, 64'h5b75ab190fffffff, 64'ha75ab7981831ffff,
    64'hb12b17751fffffff, 64'h08312717572bffff, 64'h9759279022b7ffff, 64'h75272b592328982f,
    64'h25a235375fffffff, 64'h820852875a25ffff, 64'h9015a35373a2ffff, 64'h982921872a25752f,
    64'h135375ffffffffff, 64'h087071175fffffff, 64'h903935537fffffff, 64'h987597ffffffffff,
    64'h5845a8ab8fffffff, 64'h5045b05abb30ffff, 64'h01984a8aba45ffff, 64'hab4a45b34941314f,
    64'h2512852b8458ffff, 64'h04b0b345b2b151bf, 64'h0250592b5458b85f, 64'h9452b3ffffffffff,
    64'h25a352345384ffff, 64'h5a2524420fffffff, 64'h3a235a385458019f, 64'h5a2524192942ffff,
    64'h845853351fffffff, 64'h045105ffffffffff, 64'h845853905035ffff, 64'h945fffffffffffff,
    64'h4b749b9abfffffff, 64'h0834979b79abffff, 64'h1ab1b414074bffff, 64'h3143481a474bab4f,
    64'h4b79b492b912ffff, 64'h9749b791b2b1083f, 64'hb74b42240fffffff, 64'hb74b42834324ffff,
    64'h29a279237749ffff, 64'h9a7974a27870207f, 64'h37a3a274a1a040af, 64'h1a2874ffffffffff,
    64'h491417713fffffff, 64'h491417081871ffff, 64'h403743ffffffffff, 64'h487fffffffffffff,
    64'h9a8ab8ffffffffff, 64'h30939bb9afffffff, 64'h01a0a88abfffffff, 64'h31ab3affffffffff,
    64'h12b1b99b8fffffff, 64'h30939b1292b9ffff, 64'h02b80bffffffffff, 64'h32bfffffffffffff,
    64'h23828aa89fffffff, 64'h9a2092ffffffffff, 64'h23828a0181a8ffff, 64'h1a2fffffffffffff,
    64'h138918ffffffffff, 64'h091fffffffffffff, 64'h038fffffffffffff, 64'hffffffffffffffff
  };

  // Edge code at a given place in a case's edge list.
  function automatic logic [3:0] tri_nibble(logic [7:0] cs, logic [3:0] slot);
    logic [63:0] row;
    row = TriTable[cs];
    return row[{4'd15 - slot, 2'b00} +: 4];
  endfunction

  // Number of triangles listed for a case.
  function automatic logic [2:0] tri_count(logic [7:0] cs);
    logic [63:0] row;
    logic [2:0]  n;
    row = TriTable[cs];
    n = 3'd0;
    for (int k = 0; k < 5; k++) begin
      if (row[63 - 12 * k -: 4] != 4'hf) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

  // First corner of a cube edge.
  function automatic logic [2:0] edge_from(logic [3:0] e);
    return e[3] ? {1'b0, e[1:0]} : e[2:0];
  endfunction

  // Second corner of a cube edge.
  function automatic logic [2:0] edge_to(logic [3:0] e);
    return e[3] ? {1'b1, e[1:0]} : {e[2], e[1:0] + 2'd1};
  endfunction

  // Grid offset of a corner along one axis.
  function automatic logic corner_off(logic [2:0] c, logic [1:0] axis);
    logic o;
    unique case (axis)
      2'd0:    o = c[0] ^ c[1];
      2'd1:    o = c[1];
      default: o = c[2];
    endcase
    return o;
  endfunction

endpackage

@@ rtl/core/mcc_ctrl.sv @@
module mcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               last_o,
  input  mcc_pkg::dp_stat_t  stat_i,
  output mcc_pkg::dp_cmd_t   cmd_o
);

  mcc_pkg::state_e state_q, state_d;
  logic [2:0] tri_q, tri_d;
  logic [1:0] vert_q, vert_d;
  logic [1:0] axis_q, axis_d;
  logic [4:0] cnt_q, cnt_d;
  logic       last_tri;

  // State and loop counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcc_pkg::S_IDLE;
      tri_q   <= '0;
      vert_q  <= '0;
      axis_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      tri_q   <= tri_d;
      vert_q  <= vert_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  assign last_tri = (tri_q == 3'(stat_i.ntri - 3'd1));
  assign last_o   = last_tri;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    tri_d       = tri_q;
    vert_d      = vert_q;
    axis_d      = axis_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.slot  = 4'(tri_q) * 4'd3 + 4'(vert_q);
    cmd_o.vert  = vert_q;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      mcc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mcc_pkg::S_CHECK;
        end
      end
      mcc_pkg::S_CHECK: begin
        tri_d  = '0;
        vert_d = '0;
        axis_d = '0;
        if (!stat_i.grid_ok || stat_i.ntri == 3'd0) begin
          state_d = mcc_pkg::S_IDLE;
        end else begin
          state_d = mcc_pkg::S_EDGE;
        end
      end
      mcc_pkg::S_EDGE: begin
        cmd_o.edge_setup = 1'b1;
        axis_d           = '0;
        cnt_d            = '0;
        state_d          = stat_i.need_div ? mcc_pkg::S_DIV : mcc_pkg::S_MUL;
      end
      mcc_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'(mcc_pkg::DivSteps - 1)) begin
          state_d = mcc_pkg::S_ROUND;
        end
      end
      mcc_pkg::S_ROUND: begin
        cmd_o.div_round = 1'b1;
        state_d         = mcc_pkg::S_MUL;
      end
      mcc_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = mcc_pkg::S_ACC;
      end
      mcc_pkg::S_ACC: begin
        cmd_o.acc = 1'b1;
        if (axis_q != 2'd2) begin
          axis_d  = axis_q + 2'd1;
          state_d = mcc_pkg::S_MUL;
        end else if (vert_q != 2'd2) begin
          vert_d  = vert_q + 2'd1;
          state_d = mcc_pkg::S_EDGE;
        end else begin
          state_d = mcc_pkg::S_OUT;
        end
      end
      mcc_pkg::S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (last_tri) begin
            state_d = mcc_pkg::S_IDLE;
          end else begin
            tri_d   = tri_q + 3'd1;
            vert_d  = '0;
            state_d = mcc_pkg::S_EDGE;
          end
        end
      end
      default: state_d = mcc_pkg::S_IDLE;
    endcase
  end

endmodule

@@ rtl/core/mcc_dp.sv @@
module mcc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [7:0]         cube_x_i,
  input  logic [7:0]         cube_y_i,
  input  logic [7:0]         cube_z_i,
  input  logic signed [15:0] corner_v0_i,
  input  logic signed [15:0] corner_v1_i,
  input  logic signed [15:0] corner_v2_i,
  input  logic signed [15:0] corner_v3_i,
  input  logic signed [15:0] corner_v4_i,
  input  logic signed [15:0] corner_v5_i,
  input  logic signed [15:0] corner_v6_i,
  input  logic signed [15:0] corner_v7_i,
  input  mcc_pkg::dp_cmd_t   cmd_i,
  output mcc_pkg::dp_stat_t  stat_o,
  output logic signed [31:0] ax_o,
  output logic signed [31:0] ay_o,
  output logic signed [31:0] az_o,
  output logic signed [31:0] bx_o,
  output logic signed [31:0] by_coord_o,
  output logic signed [31:0] bz_o,
  output logic signed [31:0] cx_o,
  output logic signed [31:0] cy_o,
  output logic signed [31:0] cz_o
);

  // Configuration registers.
  logic signed [15:0] thr_q;
  logic        [31:0] voxel_q;
  logic signed [31:0] org_x_q, org_y_q, org_z_q;

  // Cube held for the duration of its work.
  logic [7:0]         idx_x_q, idx_y_q, idx_z_q;
  logic signed [15:0] val_q [8];
  logic [7:0]         case_q;
  logic               grid_ok_q;

  // Edge in progress and its crossing fraction.
  logic [2:0]  from_q, to_q;
  logic [16:0] t_q;
  logic [17:0] rem_q;
  logic [16:0] div_q;
  logic [16:0] quo_q;

  // Product and finished vertices.
  logic [56:0]        prod_q;
  logic signed [31:0] coord_q [3][3];

  logic [7:0]         cs_in;
  logic               grid_in;
  logic signed [16:0] edge_n [12];
  logic signed [16:0] edge_d [12];
  logic [3:0]         nib, ecode;
  logic signed [16:0] n_sel, d_sel;
  logic [16:0]        n_abs, d_abs;
  logic               t_zero, t_half, t_one;
  logic [17:0]        rem_sh;
  logic [17:0]        q_inc;
  logic [7:0]         idx_a;
  logic signed [31:0] org_a;
  logic               off_s, off_f;
  logic [24:0]        base, pos;
  logic [41:0]        rnd;
  logic signed [43:0] sum;
  logic signed [31:0] sat;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      voxel_q <= 32'h0001_0000;
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (mcc_pkg::cfg_reg_e'(cfg_index_i))
        mcc_pkg::REG_ISO:   thr_q   <= cfg_data_i[15:0];
        mcc_pkg::REG_VOXEL: voxel_q <= cfg_data_i;
        mcc_pkg::REG_ORG_X: org_x_q <= cfg_data_i;
        mcc_pkg::REG_ORG_Y: org_y_q <= cfg_data_i;
        mcc_pkg::REG_ORG_Z: org_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Case index and grid check of the incoming cube.
  always_comb begin
    cs_in[0] = corner_v0_i <= thr_q;
    cs_in[1] = corner_v1_i <= thr_q;
    cs_in[2] = corner_v2_i <= thr_q;
    cs_in[3] = corner_v3_i <= thr_q;
    cs_in[4] = corner_v4_i <= thr_q;
    cs_in[5] = corner_v5_i <= thr_q;
    cs_in[6] = corner_v6_i <= thr_q;
    cs_in[7] = corner_v7_i <= thr_q;
    grid_in  = ({1'b0, cube_x_i} <= 9'(mcc_pkg::GridSize - 2)) &&
               ({1'b0, cube_y_i} <= 9'(mcc_pkg::GridSize - 2)) &&
               ({1'b0, cube_z_i} <= 9'(mcc_pkg::GridSize - 2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_q    <= '0;
      grid_ok_q <= 1'b0;
    end else if (cmd_i.load) begin
      case_q    <= cs_in;
      grid_ok_q <= grid_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_x_q  <= cube_x_i;
      idx_y_q  <= cube_y_i;
      idx_z_q  <= cube_z_i;
      val_q[0] <= corner_v0_i;
      val_q[1] <= corner_v1_i;
      val_q[2] <= corner_v2_i;
      val_q[3] <= corner_v3_i;
      val_q[4] <= corner_v4_i;
      val_q[5] <= corner_v5_i;
      val_q[6] <= corner_v6_i;
      val_q[7] <= corner_v7_i;
    end
  end

  // Numerator and denominator of every edge's crossing.
  always_comb begin
    for (int j = 0; j < 12; j++) begin
      edge_n[j] = 17'(thr_q) - 17'(val_q[mcc_pkg::edge_from(4'(j))]);
      edge_d[j] = 17'(val_q[mcc_pkg::edge_to(4'(j))]) -
                  17'(val_q[mcc_pkg::edge_from(4'(j))]);
    end
  end

  // Crossing of the edge named by the current table slot.
  always_comb begin
    nib    = mcc_pkg::tri_nibble(case_q, cmd_i.slot);
    ecode  = (nib > 4'd11) ? 4'd0 : nib;
    n_sel  = edge_n[ecode];
    d_sel  = edge_d[ecode];
    n_abs  = n_sel[16] ? 17'(-n_sel) : 17'(n_sel);
    d_abs  = n_sel[16] ? 17'(-d_sel) : 17'(d_sel);
    t_half = (d_sel == '0);
    t_zero = !t_half && ((n_sel == '0) || (n_sel[16] != d_sel[16]));
    t_one  = !t_half && !t_zero && (n_abs >= d_abs);
  end

  assign stat_o.grid_ok  = grid_ok_q;
  assign stat_o.ntri     = mcc_pkg::tri_count(case_q);
  assign stat_o.need_div = !t_half && !t_zero && !t_one;

  // Serial restoring divider: one quotient bit a cycle.
  assign rem_sh = {rem_q[16:0], 1'b0};
  assign q_inc  = {1'b0, quo_q} + 18'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_setup) begin
      from_q <= mcc_pkg::edge_from(ecode);
      to_q   <= mcc_pkg::edge_to(ecode);
      rem_q  <= {1'b0, n_abs};
      div_q  <= d_abs;
      quo_q  <= '0;
      if (t_half) begin
        t_q <= 17'd32768;
      end else if (t_zero) begin
        t_q <= '0;
      end else begin
        t_q <= 17'd65536;
      end
    end
    if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, div_q}) begin
        rem_q <= rem_sh - {1'b0, div_q};
        quo_q <= {quo_q[15:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[15:0], 1'b0};
      end
    end
    if (cmd_i.div_round) begin
      t_q <= q_inc[17:1];
    end
  end

  // Grid position on the current axis, scaled by the voxel size.
  always_comb begin
    unique case (cmd_i.axis)
      2'd0: begin
        idx_a = idx_x_q;
        org_a = org_x_q;
      end
      2'd1: begin
        idx_a = idx_y_q;
        org_a = org_y_q;
      end
      default: begin
        idx_a = idx_z_q;
        org_a = org_z_q;
      end
    endcase
    off_s = mcc_pkg::corner_off(from_q, cmd_i.axis);
    off_f = mcc_pkg::corner_off(to_q, cmd_i.axis);
    base  = {9'({1'b0, idx_a} + {8'd0, off_s}), 16'd0};
    if (off_f && !off_s) begin
      pos = base + 25'(t_q);
    end else if (off_s && !off_f) begin
      pos = base - 25'(t_q);
    end else begin
      pos = base;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= 57'(pos) * 57'(voxel_q);
    end
  end

  // Round back to Q16.16, add the origin and saturate.
  always_comb begin
    rnd = 42'((58'(prod_q) + 58'd32768) >> 16);
    sum = $signed({2'b00, rnd}) + 44'(org_a);
    if (sum > 44'sd2147483647) begin
      sat = 32'sh7fff_ffff;
    end else if (sum < -44'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      for (int v = 0; v < 3; v++) begin
        for (int a = 0; a < 3; a++) begin
          if (cmd_i.vert == 2'(v) && cmd_i.axis == 2'(a)) begin
            coord_q[v][a] <= sat;
          end
        end
      end
    end
  end

  assign ax_o       = coord_q[0][0];
  assign ay_o       = coord_q[0][1];
  assign az_o       = coord_q[0][2];
  assign bx_o       = coord_q[1][0];
  assign by_coord_o = coord_q[1][1];
  assign bz_o       = coord_q[1][2];
  assign cx_o       = coord_q[2][0];
  assign cy_o       = coord_q[2][1];
  assign cz_o       = coord_q[2][2];

endmodule

@@ rtl/core/marching_cubes_cell.sv @@
// One cube of a marching-cubes surface extractor. A word on the input channel
// is one cube: its base grid index and eight Q8.8 corner values. For each cube
// the block sends zero to five words on the output channel, one triangle each,
// with last_triangle_o set on the final one. Cubes with no cut edges, or whose
// index lies outside the grid, send nothing.
// The configuration channel writes threshold, voxel size and origin; it is
// always ready and should be used only while no cube is in flight.
// A triangle vertex whose edge crossing needs a division first runs the serial
// divider, which yields one quotient bit a cycle (17 steps); one shared
// multiplier then scales the three axes in turn, and each triangle ends in an
// output state. Each cube first passes an intake and a case lookup step.
// One cube is processed at a time.
// The output word is held in registers until taken; while the receiver
// stalls, the block waits and does not accept a new cube.
// Reset returns the controller to idle and the configuration to threshold 0,
// voxel size 1.0 and origin 0; no clearing pass is needed.
module marching_cubes_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         cube_x_i,
  input  logic [7:0]         cube_y_i,
  input  logic [7:0]         cube_z_i,
  input  logic signed [15:0] corner_v0_i,
  input  logic signed [15:0] corner_v1_i,
  input  logic signed [15:0] corner_v2_i,
  input  logic signed [15:0] corner_v3_i,
  input  logic signed [15:0] corner_v4_i,
  input  logic signed [15:0] corner_v5_i,
  input  logic signed [15:0] corner_v6_i,
  input  logic signed [15:0] corner_v7_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] ax_o,
  output logic signed [31:0] ay_o,
  output logic signed [31:0] az_o,
  output logic signed [31:0] bx_o,
  output logic signed [31:0] by_coord_o,
  output logic signed [31:0] bz_o,
  output logic signed [31:0] cx_o,
  output logic signed [31:0] cy_o,
  output logic signed [31:0] cz_o,
  output logic               last_triangle_o
);

  mcc_pkg::dp_cmd_t  cmd;
  mcc_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  mcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_triangle_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and storage.
  mcc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cube_x_i    (cube_x_i),
    .cube_y_i    (cube_y_i),
    .cube_z_i    (cube_z_i),
    .corner_v0_i (corner_v0_i),
    .corner_v1_i (corner_v1_i),
    .corner_v2_i (corner_v2_i),
    .corner_v3_i (corner_v3_i),
    .corner_v4_i (corner_v4_i),
    .corner_v5_i (corner_v5_i),
    .corner_v6_i (corner_v6_i),
    .corner_v7_i (corner_v7_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .ax_o        (ax_o),
    .ay_o        (ay_o),
    .az_o        (az_o),
    .bx_o        (bx_o),
    .by_coord_o  (by_coord_o),
    .bz_o        (bz_o),
    .cx_o        (cx_o),
    .cy_o        (cy_o),
    .cz_o        (cz_o)
  );

  // A cube is never taken while a triangle is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a triangle is on offer");

  // Once a cube is taken, the block is busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after a cube was taken");

  // After a triangle that is not the last, the next one is still being built.
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_triangle_o) |=> (!out_valid_o && !in_ready_o))
    else $error("cube ended or triangle repeated before its last triangle");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned GridLast = mcc_pkg::GridSize - 2;

  typedef struct {
    logic [7:0]         x;
    logic [7:0]         y;
    logic [7:0]         z;
    logic signed [15:0] v [8];
  } cube_t;

  typedef struct {
    logic signed [31:0] vtx [9];
    logic               last;
  } triangle_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  mcc_pkg::cfg_reg_e  cfg_index_i;
  logic [31:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         cube_x_i, cube_y_i, cube_z_i;
  logic signed [15:0] corner_v_i [8];
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] ax_o, ay_o, az_o, bx_o, by_coord_o, bz_o, cx_o, cy_o, cz_o;
  logic               last_triangle_o;

  // Copy of the block's registers, updated as each write is taken.
  logic signed [15:0] iso_level;
  logic [31:0]        voxel_len;
  logic signed [31:0] world_origin [3];

  triangle_t   pending_triangles [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;

  // Cut edges per case, three hex digits to a triangle.
  string tri_rows [256] = '{
    "","083","019","183981","12a","08312a","92a029","2832a8a98",
    "3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
    "478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
    "8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4",
    "47890b9bab03","47b4b99ba",
    "954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
    "95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba",
    "54050b5bab03","54858aa8b",
    "978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
    "2a5253357",
    "7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b",
    "5705097b010aba0","ba0b03a50807570","ba57b5",
    "a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
    "23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6",
    "3b6036065059","65969bb98",
    "5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347",
    "847905065026","739794329596269",
    "3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
    "51b5b610b7b404b","059065036b63847","65969b4797b9",
    "a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
    "832824426",
    "a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
    "8b1810b61914641","3b6360064","648b68",
    "7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867",
    "269291679093739","780706602","732672",
    "23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671","896867916b63136",
    "091b67","7807063b0b60","7b6",
    "76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
    "723627","708760620","276237019","162181198876","a76a17137","a7617a187108",
    "03707a0a96a7","76a7a88a9",
    "684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046",
    "4b846b0292a9","a93a32943b36463",
    "823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
    "4634386a3039a93","a946a4",
    "49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495",
    "76b54a42a402","348354325a52b76",
    "723762549","954086062687","362376150540","628687218485158","954a16176137",
    "16a176107870954","40a4a503a6a737a","76a7a854a48a",
    "6956b9b89","36b036056095","0b805b01556b","6b3635531","12a95b9b8b56",
    "0b306b09656912a","b85b56805a52025","6b36352a3a53",
    "589528562382","956960062","158180568382628","156216","13616a386569896",
    "a10a06950560","03856a","a56",
    "b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b17751","08312717572b",
    "9759279022b7","75272b592328982",
    "25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
    "903935537","987597",
    "5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
    "04b0b345b2b151b","0250592b5458b85","9452b3",
    "25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
    "845853905035","945",
    "4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
    "9749b791b2b1083","b74b42240","b74b42834324",
    "29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713",
    "491417081871","403743","487",
    "9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
    "23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
  };

  // Corners at the two ends of each cube edge.
  int unsigned edge_start [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
  int unsigned edge_end   [12] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

  marching_cubes_cell DUT (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cube_x_i, .cube_y_i, .cube_z_i,
    .corner_v0_i(corner_v_i[0]), .corner_v1_i(corner_v_i[1]),
    .corner_v2_i(corner_v_i[2]), .corner_v3_i(corner_v_i[3]),
    .corner_v4_i(corner_v_i[4]), .corner_v5_i(corner_v_i[5]),
    .corner_v6_i(corner_v_i[6]), .corner_v7_i(corner_v_i[7]),
    .out_valid_o, .out_ready_i, .ax_o, .ay_o, .az_o, .bx_o, .by_coord_o, .bz_o,
    .cx_o, .cy_o, .cz_o, .last_triangle_o
  );

  always #5 clk_i = ~clk_i;

  // Grid offset of a corner along one axis.
  function automatic longint corner_shift(int unsigned c, int unsigned axis);
    if (axis == 0) return ((c & 3) == 1 || (c & 3) == 2) ? 1 : 0;
    if (axis == 1) return ((c & 3) >= 2) ? 1 : 0;
    return (c >> 2) & 1;
  endfunction

  // Crossing point along an edge as a Q0.16 fraction, rounded half up.
  function automatic longint cut_fraction(longint va, longint vb, longint lvl);
    longint d, n;
    d = vb - va;
    n = lvl - va;
    if (d == 0) return 32768;
    if (n == 0 || ((n < 0) != (d < 0))) return 0;
    if (n < 0) begin
      n = -n;
      d = -d;
    end
    if (n >= d) return 65536;
    return (n * 131072 + d) / (2 * d);
  endfunction

  // Grid position scaled by the voxel length, shifted by the origin, saturated.
  function automatic logic signed [31:0] to_world(longint pos, longint org);
    longint r;
    r = ((pos * longint'(voxel_len) + 32768) >>> 16) + org;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Works out the triangles a cube produces and queues them.
  task automatic predict_triangles(input cube_t c);
    longint      idx [3];
    int unsigned cs, ntri, e, s, f;
    byte         ch;
    longint      t;
    triangle_t   item;
    idx[0] = c.x;
    idx[1] = c.y;
    idx[2] = c.z;
    if (c.x > GridLast || c.y > GridLast || c.z > GridLast) return;
    cs = 0;
    for (int i = 0; i < 8; i++) if (c.v[i] <= iso_level) cs |= 1 << i;
    ntri = tri_rows[cs].len() / 3;
    for (int k = 0; k < ntri; k++) begin
      for (int i = 0; i < 3; i++) begin
        ch = tri_rows[cs][3 * k + i];
        e = (ch <= "9") ? ch - "0" : ch - "a" + 10;
        s = edge_start[e];
        f = edge_end[e];
        t = cut_fraction(c.v[s], c.v[f], iso_level);
        for (int a = 0; a < 3; a++) begin
          item.vtx[3 * i + a] = to_world((idx[a] + corner_shift(s, a)) * 65536
              + (corner_shift(f, a) - corner_shift(s, a)) * t, world_origin[a]);
        end
      end
      item.last = (k + 1 == ntri);
      pending_triangles = {pending_triangles, item};
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0d: %s got %h expected %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Sends one cube, with a random gap first unless the tail is running.
  task automatic send_cube(input cube_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cube_x_i <= c.x;
    cube_y_i <= c.y;
    cube_z_i <= c.z;
    for (int i = 0; i < 8; i++) corner_v_i[i] <= c.v[i];
    do @(posedge clk_i); while (!in_ready_o);
    predict_triangles(c);
  endtask

  // Waits until the block has finished all work.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_triangles.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input mcc_pkg::cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mcc_pkg::REG_ISO:   iso_level = data[15:0];
      mcc_pkg::REG_VOXEL: voxel_len = data;
      mcc_pkg::REG_ORG_X: world_origin[0] = data;
      mcc_pkg::REG_ORG_Y: world_origin[1] = data;
      mcc_pkg::REG_ORG_Z: world_origin[2] = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] lvl, input logic [31:0] vox,
                            input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz);
    drain();
    write_reg(mcc_pkg::REG_ISO, {{16{lvl[15]}}, lvl});
    write_reg(mcc_pkg::REG_VOXEL, vox);
    write_reg(mcc_pkg::REG_ORG_X, ox);
    write_reg(mcc_pkg::REG_ORG_Y, oy);
    write_reg(mcc_pkg::REG_ORG_Z, oz);
  endtask

  // A corner value a random distance inside or outside the surface.
  function automatic logic signed [15:0] corner_near(bit is_in, int unsigned spread);
    int v;
    v = is_in ? int'(iso_level) - int'($urandom_range(0, spread))
              : int'(iso_level) + 1 + int'($urandom_range(0, spread));
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v[15:0];
  endfunction

  // Well-formed cubes pick a case and place corners around the surface;
  // the rest are raw noise over the whole field range.
  task automatic send_random_cube(input bit well_formed);
    cube_t       c;
    int unsigned cs;
    cs = $urandom_range(0, 255);
    c.x = 8'($urandom_range(0, GridLast));
    c.y = 8'($urandom_range(0, GridLast));
    c.z = 8'($urandom_range(0, GridLast));
    if ($urandom_range(0, 19) == 0) c.x = 8'hff;
    if ($urandom_range(0, 19) == 0) c.z = 8'(GridLast + 1);
    for (int i = 0; i < 8; i++) begin
      c.v[i] = well_formed ? corner_near(cs[i], $urandom_range(0, 1) ? 255 : 32767)
                           : 16'($urandom);
    end
    if (!well_formed && $urandom_range(0, 1)) begin
      c.x = 8'($urandom);
      c.y = 8'($urandom);
    end
    send_cube(c);
  endtask

  function automatic cube_t case_cube(input logic [7:0] cs, input logic [7:0] x,
                                      input logic signed [15:0] lo,
                                      input logic signed [15:0] hi);
    cube_t c;
    c.x = x;
    c.y = x;
    c.z = x;
    for (int i = 0; i < 8; i++) c.v[i] = cs[i] ? lo : hi;
    return c;
  endfunction

  // Corner cases with the reset settings: empty cubes, one corner, the case
  // with five triangles, grid edges and full-range corner values.
  task automatic test_directed_cases();
    cube_t c;
    send_cube(case_cube(8'h00, 8'd0, -16'sd256, 16'sd256));
    send_cube(case_cube(8'hff, 8'd3, -16'sd256, 16'sd256));
    send_cube(case_cube(8'h01, 8'd0, -16'sd256, 16'sd256));
    send_cube(case_cube(8'h3d, 8'd10, -16'sd32768, 16'sd32767));
    send_cube(case_cube(8'h3c, GridLast[7:0], -16'sd1, 16'sd1));
    send_cube(case_cube(8'h01, GridLast[7:0] + 8'd1, -16'sd256, 16'sd256));
    send_cube(case_cube(8'h01, 8'hff, -16'sd256, 16'sd256));
    send_cube(case_cube(8'h81, 8'd7, 16'sd0, 16'sd32767));
    // Corner exactly on the surface counts as inside and cuts at zero.
    c = case_cube(8'h10, 8'd1, 16'sd0, 16'sd3);
    send_cube(c);
    c = case_cube(8'h66, 8'd200, -16'sd32768, 16'sd1);
    c.y = 8'd0;
    send_cube(c);
    c = case_cube(8'ha5, 8'd50, -16'sd7, 16'sd32767);
    c.z = 8'd254;
    send_cube(c);
  endtask

  // Register extremes: saturation at both ends, zero and maximum voxel size.
  task automatic test_config_extremes();
    set_config(16'h7fff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_cube(case_cube(8'h01, 8'd254, 16'sh7fff, 16'sh7fff));
    send_cube(case_cube(8'h7e, 8'd0, -16'sd32768, 16'sd32767));
    set_config(16'h8000, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_cube(case_cube(8'h01, 8'd9, -16'sd32768, 16'sd32767));
    send_cube(case_cube(8'hfe, 8'd254, -16'sd32768, 16'sd32767));
    set_config(16'h0080, 32'hffff_ffff, 32'h0, 32'h0, 32'h0);
    send_cube(case_cube(8'h3d, 8'd254, 16'sd0, 16'sd300));
    send_cube(case_cube(8'hc3, 8'd128, -16'sd32768, 16'sd32767));
  endtask

  // Random cubes over several register settings.
  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      set_config(16'($urandom), (p == 0) ? 32'h0001_0000 : $urandom_range(0, 1) ? $urandom
                 : $urandom_range(0, 32'h0004_0000), $urandom, $urandom, $urandom);
      repeat (50) send_random_cube($urandom_range(0, 4) != 0);
    end
  endtask

  // Back-to-back cubes with the receiver always ready.
  task automatic test_calm_tail();
    set_config(16'($urandom), 32'h0000_8000, 32'hfff0_0000, 32'h0010_0000, 32'h0);
    calm = 1'b1;
    repeat (40) send_random_cube(1'b1);
  endtask

  // Receiver stalls in random bursts.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compares each triangle taken with the oldest one predicted.
  always @(posedge clk_i) begin
    logic signed [31:0] got [9];
    triangle_t          want;
    string              names [9];
    names = '{"ax", "ay", "az", "bx", "by_coord", "bz", "cx", "cy", "cz"};
    got = '{ax_o, ay_o, az_o, bx_o, by_coord_o, bz_o, cx_o, cy_o, cz_o};
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_triangles.size() == 0) begin
        report("unexpected triangle ax", ax_o, 32'h0);
      end else begin
        want = pending_triangles.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== want.vtx[i]) report(names[i], got[i], want.vtx[i]);
        end
        if (last_triangle_o !== want.last) report("last_triangle", last_triangle_o, want.last);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mcc_pkg::REG_ISO;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    cube_x_i = '0;
    cube_y_i = '0;
    cube_z_i = '0;
    for (int i = 0; i < 8; i++) corner_v_i[i] = '0;
    iso_level = '0;
    voxel_len = 32'h0001_0000;
    for (int a = 0; a < 3; a++) world_origin[a] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_config_extremes();
    test_random_phases();
    test_calm_tail();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
